### rtl/pa_pkg.sv
package pa_pkg;

   localparam int INDEX_BITS_DEFAULT = 16;

   localparam int MODE_BITS = 3;
   localparam int SLOT_BITS = 2;
   localparam int SIZE_BITS = 3;
   localparam int MASK_BITS = 4;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_TRI_STRIP  = 3'd0,
      MODE_TRI_FAN    = 3'd1,
      MODE_TRIANGLES  = 3'd2,
      MODE_QUAD_STRIP = 3'd3,
      MODE_QUADS      = 3'd4
   } draw_mode_type;

   localparam logic [MODE_BITS-1:0] MODE_RESET = MODE_TRIANGLES;

   localparam logic [SIZE_BITS-1:0] TRI_SIZE  = 3'd3;
   localparam logic [SIZE_BITS-1:0] QUAD_SIZE = 3'd4;

   localparam logic [MASK_BITS-1:0] TRI_SLOTS_MASK = 4'b0111;
   localparam logic [MASK_BITS-1:0] KEEP_HIGH_PAIR = 4'b1100;
   localparam logic [MASK_BITS-1:0] KEEP_LOW_PAIR  = 4'b0011;

   typedef struct packed {
      logic [SLOT_BITS-1:0] fill_count;
      logic                 first_done;
      logic [SLOT_BITS-1:0] replace_slot;
      logic                 inverted_flag;
   } asm_state_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0] slot;
      logic                 facet_ready;
      logic [SIZE_BITS-1:0] facet_size;
      logic                 facet_inverted;
      logic [MASK_BITS-1:0] keep_mask;
   } facet_info_type;

endpackage

### rtl/pa_if.sv
interface pa_req_if #(
   parameter int INDEX_BITS = pa_pkg::INDEX_BITS_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic [INDEX_BITS-1:0] vertex_index;
   logic                  array_start;

   modport source (output valid, output vertex_index, output array_start, input ready);
   modport sink (input valid, input vertex_index, input array_start, output ready);
endinterface

interface pa_rsp_if #(
   parameter int INDEX_BITS = pa_pkg::INDEX_BITS_DEFAULT
);
   logic                           valid;
   logic                           ready;
   logic [pa_pkg::SLOT_BITS-1:0]   slot;
   logic                           facet_ready;
   logic [pa_pkg::SIZE_BITS-1:0]   facet_size;
   logic                           facet_inverted;
   logic [pa_pkg::MASK_BITS-1:0]   keep_mask;
   logic [INDEX_BITS-1:0]          color_vertex;

   modport source (output valid, output slot, output facet_ready, output facet_size,
                   output facet_inverted, output keep_mask, output color_vertex,
                   input ready);
   modport sink (input valid, input slot, input facet_ready, input facet_size,
                 input facet_inverted, input keep_mask, input color_vertex,
                 output ready);
endinterface

interface pa_csr_if;
   logic                         valid;
   logic                         ready;
   logic [pa_pkg::MODE_BITS-1:0] draw_mode;

   modport source (output valid, output draw_mode, input ready);
   modport sink (input valid, input draw_mode, output ready);
endinterface

### rtl/pa_step.sv
module pa_step #(
   parameter int INDEX_BITS = pa_pkg::INDEX_BITS_DEFAULT
) (
   input  logic [pa_pkg::MODE_BITS-1:0] mode,
   input  pa_pkg::asm_state_type        state_cur,
   input  logic [INDEX_BITS-1:0]        first_index_cur,
   input  logic [INDEX_BITS-1:0]        vertex_index,
   input  logic                         array_start,
   output pa_pkg::asm_state_type        state_nxt,
   output logic [INDEX_BITS-1:0]        first_index_nxt,
   output pa_pkg::facet_info_type       info,
   output logic [INDEX_BITS-1:0]        color_vertex
);

   pa_pkg::asm_state_type       st;
   logic [INDEX_BITS-1:0]       fi;
   logic [pa_pkg::SIZE_BITS-1:0] list_size;
   logic                        is_fan;

   always_comb begin
      st = array_start ? '0 : state_cur;
      fi = array_start ? '0 : first_index_cur;
      is_fan = (mode == pa_pkg::MODE_TRI_FAN);
      list_size = (mode == pa_pkg::MODE_TRIANGLES) ? pa_pkg::TRI_SIZE : pa_pkg::QUAD_SIZE;
      state_nxt = st;
      first_index_nxt = fi;
      info = '0;
      color_vertex = '0;

      unique case (mode)
         pa_pkg::MODE_TRI_STRIP, pa_pkg::MODE_TRI_FAN: begin
            if (!st.first_done) begin
               info.slot = st.fill_count;
               if (st.fill_count == 2'd2) begin
                  info.facet_ready = 1'b1;
                  info.facet_size = pa_pkg::TRI_SIZE;
                  color_vertex = vertex_index;
                  state_nxt.first_done = 1'b1;
                  state_nxt.fill_count = '0;
                  state_nxt.inverted_flag = 1'b0;
                  state_nxt.replace_slot = is_fan ? 2'd1 : 2'd0;
               end else begin
                  state_nxt.fill_count = st.fill_count + 2'd1;
               end
            end else begin
               info.slot = st.replace_slot;
               info.facet_ready = 1'b1;
               info.facet_size = pa_pkg::TRI_SIZE;
               info.facet_inverted = ~st.inverted_flag;
               info.keep_mask = pa_pkg::TRI_SLOTS_MASK & ~(4'd1 << st.replace_slot);
               color_vertex = vertex_index;
               state_nxt.inverted_flag = ~st.inverted_flag;
               if (st.replace_slot >= 2'd2) begin
                  state_nxt.replace_slot = is_fan ? 2'd1 : 2'd0;
               end else begin
                  state_nxt.replace_slot = st.replace_slot + 2'd1;
               end
            end
         end
         pa_pkg::MODE_QUAD_STRIP: begin
            if (!st.first_done) begin
               unique case (st.fill_count)
                  2'd0: info.slot = 2'd0;
                  2'd1: info.slot = 2'd1;
                  2'd2: info.slot = 2'd3;
                  default: info.slot = 2'd2;
               endcase
               if (st.fill_count == 2'd3) begin
                  info.facet_ready = 1'b1;
                  info.facet_size = pa_pkg::QUAD_SIZE;
                  color_vertex = vertex_index;
                  state_nxt.first_done = 1'b1;
                  state_nxt.fill_count = '0;
                  state_nxt.inverted_flag = 1'b0;
                  state_nxt.replace_slot = '0;
               end else begin
                  state_nxt.fill_count = st.fill_count + 2'd1;
               end
            end else if (st.fill_count == 2'd0) begin
               info.slot = (st.replace_slot == 2'd0) ? 2'd0 : 2'd3;
               state_nxt.fill_count = 2'd1;
            end else begin
               info.slot = (st.replace_slot == 2'd0) ? 2'd1 : 2'd2;
               info.facet_ready = 1'b1;
               info.facet_size = pa_pkg::QUAD_SIZE;
               info.facet_inverted = ~st.inverted_flag;
               info.keep_mask = (st.replace_slot == 2'd0) ? pa_pkg::KEEP_HIGH_PAIR
                                                          : pa_pkg::KEEP_LOW_PAIR;
               color_vertex = vertex_index;
               state_nxt.inverted_flag = ~st.inverted_flag;
               state_nxt.replace_slot = (st.replace_slot == 2'd0) ? 2'd2 : 2'd0;
               state_nxt.fill_count = '0;
            end
         end
         default: begin
            // triangle and quad lists; undefined codes run as quads
            info.slot = st.fill_count;
            if (st.fill_count == 2'd0) begin
               first_index_nxt = vertex_index;
            end
            if ({1'b0, st.fill_count} + 3'd1 == list_size) begin
               info.facet_ready = 1'b1;
               info.facet_size = list_size;
               color_vertex = first_index_nxt;
               state_nxt.fill_count = '0;
            end else begin
               state_nxt.fill_count = st.fill_count + 2'd1;
            end
         end
      endcase
   end

endmodule

### rtl/primitive_assembler_top.sv
// Primitive assembler: takes one vertex index per beat and reports, from a
// result register, the facet slot it lands in and, when it closes a facet,
// the facet size, winding inversion, reused-slot mask and flat-color vertex.
// Draw mode is set through the csr channel (reset: triangles); a write also
// restarts assembly, as does array_start on a vertex. Throughput is one
// vertex per clock; req ready drops only while a finished result is held by
// rsp back-pressure.
// Incomplete trailing facets are dropped silently.
module primitive_assembler_top #(
   parameter int INDEX_BITS = pa_pkg::INDEX_BITS_DEFAULT
) (
   input logic   clock,
   input logic   reset,
   pa_req_if.sink   req_ch,
   pa_rsp_if.source rsp_ch,
   pa_csr_if.sink   csr_ch
);

   logic [pa_pkg::MODE_BITS-1:0] mode_ff;
   pa_pkg::asm_state_type        state_ff, state_in;
   logic [INDEX_BITS-1:0]        first_index_ff, first_index_in;
   pa_pkg::facet_info_type       info_ff, info_in;
   logic [INDEX_BITS-1:0]        color_ff, color_in;
   logic                         rsp_valid_ff;
   logic                         req_take;
   logic                         csr_take;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign req_take = req_ch.valid && req_ch.ready;
   assign csr_take = csr_ch.valid;

   pa_step #(
      .INDEX_BITS(INDEX_BITS)
   ) u_step (
      .mode            (mode_ff),
      .state_cur       (state_ff),
      .first_index_cur (first_index_ff),
      .vertex_index    (req_ch.vertex_index),
      .array_start     (req_ch.array_start),
      .state_nxt       (state_in),
      .first_index_nxt (first_index_in),
      .info            (info_in),
      .color_vertex    (color_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= pa_pkg::MODE_RESET;
         state_ff <= '0;
         first_index_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_take) begin
            mode_ff <= csr_ch.draw_mode;
            state_ff <= '0;
            first_index_ff <= '0;
         end else if (req_take) begin
            state_ff <= state_in;
            first_index_ff <= first_index_in;
         end
         if (req_take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         info_ff <= info_in;
         color_ff <= color_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.slot = info_ff.slot;
   assign rsp_ch.facet_ready = info_ff.facet_ready;
   assign rsp_ch.facet_size = info_ff.facet_size;
   assign rsp_ch.facet_inverted = info_ff.facet_inverted;
   assign rsp_ch.keep_mask = info_ff.keep_mask;
   assign rsp_ch.color_vertex = color_ff;

   a_csr_clears: assert property (@(posedge clock) disable iff (reset)
      csr_take |=> (state_ff == '0) && (first_index_ff == '0))
      else $error("assembly state not cleared by draw mode write");

   a_facet_size: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && info_ff.facet_ready) |->
         (info_ff.facet_size == pa_pkg::TRI_SIZE || info_ff.facet_size == pa_pkg::QUAD_SIZE))
      else $error("completed facet with bad size");

   a_keep_excludes_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !info_ff.keep_mask[info_ff.slot])
      else $error("kept slot overwritten by current vertex");

   a_idle_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !info_ff.facet_ready) |->
         (info_ff.facet_size == '0 && info_ff.keep_mask == '0 && color_ff == '0))
      else $error("facet fields set without a completed facet");

endmodule

### sim/tb.sv
module tb;

   localparam int INDEX_BITS = pa_pkg::INDEX_BITS_DEFAULT;
   localparam int RUN_LIMIT  = 2_000_000;

   typedef struct packed {
      logic [INDEX_BITS-1:0] idx;
      logic                  start;
   } vertex_beat_type;

   typedef struct packed {
      pa_pkg::facet_info_type info;
      logic [INDEX_BITS-1:0]  color_vertex;
   } facet_report_type;

   logic clock;
   logic reset;

   pa_req_if #(.INDEX_BITS(INDEX_BITS)) req_ch ();
   pa_rsp_if #(.INDEX_BITS(INDEX_BITS)) rsp_ch ();
   pa_csr_if csr_ch ();

   primitive_assembler_top #(.INDEX_BITS(INDEX_BITS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   vertex_beat_type  pending_beats[$];
   facet_report_type expected_reports[$];
   vertex_beat_type  next_beat;
   facet_report_type want;
   facet_report_type got;

   int send_idle_pct;
   int stall_pct;
   int mismatch_count;
   int vertices_sent;
   int results_checked;
   int facets_checked;

   // assembly state mirror
   logic [pa_pkg::MODE_BITS-1:0] active_mode;
   logic [pa_pkg::SLOT_BITS-1:0] fill_count;
   logic                         first_done;
   logic [pa_pkg::SLOT_BITS-1:0] replace_slot;
   logic                         inverted;
   logic [INDEX_BITS-1:0]        first_index;

   function automatic void clear_assembly();
      fill_count   = '0;
      first_done   = 1'b0;
      replace_slot = '0;
      inverted     = 1'b0;
      first_index  = '0;
   endfunction

   function automatic facet_report_type assemble_vertex(input logic [INDEX_BITS-1:0] idx,
                                                        input logic start);
      facet_report_type             r;
      logic [pa_pkg::MODE_BITS-1:0] mode;
      logic [pa_pkg::SIZE_BITS-1:0] n;
      r = '0;
      mode = (active_mode > pa_pkg::MODE_QUADS) ? pa_pkg::MODE_QUADS : active_mode;
      if (start) begin
         clear_assembly();
      end
      if (mode == pa_pkg::MODE_TRIANGLES || mode == pa_pkg::MODE_QUADS) begin
         n = (mode == pa_pkg::MODE_TRIANGLES) ? pa_pkg::TRI_SIZE : pa_pkg::QUAD_SIZE;
         r.info.slot = fill_count;
         if (fill_count == 0) begin
            first_index = idx;
         end
         if (fill_count + 1 >= n) begin
            r.info.facet_ready = 1'b1;
            r.info.facet_size  = n;
            r.color_vertex     = first_index;
            fill_count         = '0;
         end else begin
            fill_count++;
         end
      end else if (mode == pa_pkg::MODE_TRI_STRIP || mode == pa_pkg::MODE_TRI_FAN) begin
         if (!first_done) begin
            r.info.slot = fill_count;
            if (fill_count >= 2) begin
               r.info.facet_ready = 1'b1;
               r.info.facet_size  = pa_pkg::TRI_SIZE;
               r.color_vertex     = idx;
               first_done         = 1'b1;
               fill_count         = '0;
               inverted           = 1'b0;
               replace_slot       = (mode == pa_pkg::MODE_TRI_FAN) ? 2'd1 : 2'd0;
            end else begin
               fill_count++;
            end
         end else begin
            inverted              = ~inverted;
            r.info.slot           = replace_slot;
            r.info.facet_ready    = 1'b1;
            r.info.facet_size     = pa_pkg::TRI_SIZE;
            r.info.facet_inverted = inverted;
            r.info.keep_mask      = pa_pkg::TRI_SLOTS_MASK & ~(4'b0001 << replace_slot);
            r.color_vertex        = idx;
            if (replace_slot >= 2) begin
               replace_slot = (mode == pa_pkg::MODE_TRI_FAN) ? 2'd1 : 2'd0;
            end else begin
               replace_slot++;
            end
         end
      end else begin
         // quad strip: first facet fills 0,1,3,2, then pairs alternate 0,1 / 3,2
         if (!first_done) begin
            r.info.slot = (fill_count < 2) ? fill_count : ((fill_count == 2) ? 2'd3 : 2'd2);
            if (fill_count >= 3) begin
               r.info.facet_ready = 1'b1;
               r.info.facet_size  = pa_pkg::QUAD_SIZE;
               r.color_vertex     = idx;
               first_done         = 1'b1;
               fill_count         = '0;
               inverted           = 1'b0;
               replace_slot       = '0;
            end else begin
               fill_count++;
            end
         end else if (fill_count == 0) begin
            r.info.slot = (replace_slot == 0) ? 2'd0 : 2'd3;
            fill_count  = 2'd1;
         end else begin
            inverted              = ~inverted;
            r.info.slot           = (replace_slot == 0) ? 2'd1 : 2'd2;
            r.info.facet_ready    = 1'b1;
            r.info.facet_size     = pa_pkg::QUAD_SIZE;
            r.info.facet_inverted = inverted;
            r.info.keep_mask      = (replace_slot == 0) ? pa_pkg::KEEP_HIGH_PAIR
                                                        : pa_pkg::KEEP_LOW_PAIR;
            r.color_vertex        = idx;
            replace_slot          = (replace_slot == 0) ? 2'd2 : 2'd0;
            fill_count            = '0;
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   task automatic add_vertex(input logic [INDEX_BITS-1:0] idx, input logic start);
      vertex_beat_type b;
      b.idx   = idx;
      b.start = start;
      pending_beats.push_back(b);
   endtask

   task automatic add_random_vertices(input int count);
      logic [INDEX_BITS-1:0] idx;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(9) == 0) begin
            idx = $urandom_range(1) ? '1 : '0;
         end else begin
            idx = INDEX_BITS'($urandom);
         end
         add_vertex(idx, (i == 0) ? 1'($urandom_range(1)) : ($urandom_range(13) == 0));
      end
   endtask

   task automatic wait_idle();
      while (pending_beats.size() != 0 || req_ch.valid || expected_reports.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_mode(input logic [pa_pkg::MODE_BITS-1:0] mode);
      @(posedge clock);
      csr_ch.valid     <= 1'b1;
      csr_ch.draw_mode <= mode;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      active_mode = mode;
      clear_assembly();
   endtask

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // vertex driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_reports.push_back(assemble_vertex(req_ch.vertex_index,
                                                       req_ch.array_start));
            vertices_sent++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_beat = pending_beats.pop_front();
               req_ch.valid        <= 1'b1;
               req_ch.vertex_index <= next_beat.idx;
               req_ch.array_start  <= next_beat.start;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.info.slot           = rsp_ch.slot;
            got.info.facet_ready    = rsp_ch.facet_ready;
            got.info.facet_size     = rsp_ch.facet_size;
            got.info.facet_inverted = rsp_ch.facet_inverted;
            got.info.keep_mask      = rsp_ch.keep_mask;
            got.color_vertex        = rsp_ch.color_vertex;
            if (expected_reports.size() == 0) begin
               report_mismatch($sformatf("result beat with nothing expected: %p", got));
            end else begin
               want = expected_reports.pop_front();
               if (got.info.slot !== want.info.slot)
                  report_mismatch($sformatf("slot %0d, expected %0d",
                                            got.info.slot, want.info.slot));
               if (got.info.facet_ready !== want.info.facet_ready)
                  report_mismatch($sformatf("facet_ready %0b, expected %0b",
                                            got.info.facet_ready, want.info.facet_ready));
               if (got.info.facet_size !== want.info.facet_size)
                  report_mismatch($sformatf("facet_size %0d, expected %0d",
                                            got.info.facet_size, want.info.facet_size));
               if (got.info.facet_inverted !== want.info.facet_inverted)
                  report_mismatch($sformatf("facet_inverted %0b, expected %0b",
                                            got.info.facet_inverted,
                                            want.info.facet_inverted));
               if (got.info.keep_mask !== want.info.keep_mask)
                  report_mismatch($sformatf("keep_mask %b, expected %b",
                                            got.info.keep_mask, want.info.keep_mask));
               if (got.color_vertex !== want.color_vertex)
                  report_mismatch($sformatf("color_vertex %0h, expected %0h",
                                            got.color_vertex, want.color_vertex));
               if (want.info.facet_ready) begin
                  facets_checked++;
               end
            end
            results_checked++;
         end
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      #(RUN_LIMIT);
      $display("primitive_assembler_top test failed");
      $finish;
   end

   initial begin
      clock               = 1'b0;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.vertex_index = '0;
      req_ch.array_start  = 1'b0;
      rsp_ch.ready        = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.draw_mode    = pa_pkg::MODE_RESET;
      send_idle_pct       = 0;
      stall_pct           = 0;
      mismatch_count      = 0;
      vertices_sent       = 0;
      results_checked     = 0;
      facets_checked      = 0;
      active_mode         = pa_pkg::MODE_RESET;
      clear_assembly();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset mode triangles; array_start drops an incomplete tail
      add_vertex('0, 1'b0);
      add_vertex('1, 1'b0);
      add_vertex(16'd1, 1'b0);
      add_vertex(16'd7, 1'b0);
      add_vertex(16'd8, 1'b0);
      add_vertex(16'd9, 1'b1);
      add_vertex(16'd10, 1'b0);
      add_vertex(16'd11, 1'b0);
      // partial facet left behind, cleared by the mode write
      add_vertex(16'd3, 1'b0);
      add_vertex(16'd4, 1'b0);
      wait_idle();
      write_mode(pa_pkg::MODE_TRI_FAN);
      for (int i = 0; i < 5; i++) begin
         add_vertex(INDEX_BITS'(100 + i), i == 0);
      end
      wait_idle();
      write_mode(pa_pkg::MODE_QUAD_STRIP);
      for (int i = 0; i < 6; i++) begin
         add_vertex(INDEX_BITS'(200 + i), 1'b0);
      end
      wait_idle();
      // undefined mode value behaves as quads
      write_mode('1);
      add_vertex('1, 1'b1);
      add_vertex(16'd5, 1'b0);
      add_vertex(16'd6, 1'b0);
      add_vertex('0, 1'b0);
      wait_idle();

      for (int pass = 0; pass < 4; pass++) begin
         case (pass)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 66; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 66; end
            default: begin send_idle_pct = 21; stall_pct = 21; end
         endcase
         for (int m = 0; m < 8; m++) begin
            write_mode(pa_pkg::MODE_BITS'(m));
            add_random_vertices(54);
            wait_idle();
         end
      end

      repeat (8) @(posedge clock);
      if (expected_reports.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", expected_reports.size()));
      end
      $display("Sent %0d vertices and checked %0d results (%0d closing a facet)",
               vertices_sent, results_checked, facets_checked);
      $display("across all eight draw-mode values under four sender/receiver idle mixes.");
      if (mismatch_count == 0) begin
         $display("primitive_assembler_top test passed");
      end else begin
         $display("primitive_assembler_top test failed");
      end
      $finish;
   end

endmodule

### files.f
rtl/pa_pkg.sv
rtl/pa_if.sv
rtl/pa_step.sv
rtl/primitive_assembler_top.sv
sim/tb.sv
